[design/mirr_pkg.sv]
// ----------------------------------------------------------------------------
// mirr_pkg: multiply instruction register rewriter package
// Shared types, step codes and helpers for the rewriter front, queue and back.
// ----------------------------------------------------------------------------
package mirr_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] GroupMask  = 32'h1F00_0000;
  localparam logic [31:0] GroupMatch = 32'h1B00_0000;
  localparam logic [4:0]  RegZero    = 5'd31;
  localparam logic [4:0]  RegNine    = 5'd9;
  localparam logic [4:0]  RegScrN    = 5'd16;
  localparam logic [4:0]  RegScrM    = 5'd17;
  localparam logic [7:0]  SlotNine   = 8'(9 * 8);

  // op31 codes of the 3-source multiply group
  localparam logic [2:0] OpMadd    = 3'd0;
  localparam logic [2:0] OpSmaddl  = 3'd1;
  localparam logic [2:0] OpSmulh   = 3'd2;
  localparam logic [2:0] OpUnalloc = 3'd3;
  localparam logic [2:0] OpUmaddl  = 3'd5;
  localparam logic [2:0] OpUmulh   = 3'd6;

  localparam int unsigned NumSteps = 8;

  // step bits, lowest first in run order
  localparam int unsigned StepLoadRn   = 0;
  localparam int unsigned StepLoadRm   = 1;
  localparam int unsigned StepSave9    = 2;
  localparam int unsigned StepLoadRa   = 3;
  localparam int unsigned StepEmit     = 4;
  localparam int unsigned StepRestore9 = 5;
  localparam int unsigned StepWrBack   = 6;
  localparam int unsigned StepReject   = 7;

  typedef enum logic [2:0] {
    ActLoad   = 3'd0,
    ActStore  = 3'd1,
    ActEmit   = 3'd2,
    ActMove   = 3'd3,
    ActReject = 3'd4
  } action_e;

  typedef struct packed {
    logic [NumSteps-1:0] steps;
    logic [4:0]          rn;
    logic [4:0]          rm;
    logic [4:0]          ra;
    logic [4:0]          rd;
    logic                wb_move;
    logic [31:0]         native_word;
  } plan_t;

  typedef struct packed {
    action_e     action;
    logic [4:0]  host_reg;
    logic [4:0]  source_reg;
    logic [7:0]  slot_offset;
    logic [31:0] native_word;
    logic        last;
  } result_t;

  function automatic logic is_reserved(logic [4:0] r);
    return (r == 5'd16) || (r == 5'd17) || (r == 5'd18) || (r == 5'd28) || (r == 5'd30);
  endfunction

  function automatic logic [7:0] slot_of(logic [4:0] r);
    return {r, 3'b000};
  endfunction

endpackage

[design/multiply_instruction_register_rewriter_unit.sv]
// ----------------------------------------------------------------------------
// multiply_instruction_register_rewriter_unit: AArch64 multiply rewriter
// Accepted items enter the plan queue; each action is then registered for output.
// Throughput: one action per cycle while the result is free or popped; an item has
// one to seven actions, walked in order by the back sequencer at the queue head.
// Reset: asynchronous, clears the plan queue, sequencer progress and result valid.
// ----------------------------------------------------------------------------
module multiply_instruction_register_rewriter_unit #(
  parameter int unsigned QueueDepth = mirr_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instr_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action_o,
  output logic [4:0]  host_reg_o,
  output logic [4:0]  source_reg_o,
  output logic [7:0]  slot_offset_o,
  output logic [31:0] native_word_o,
  output logic        last_o
);

  mirr_pkg::plan_t   new_plan, head_plan;
  mirr_pkg::result_t res;
  logic              head_valid, head_pop, res_valid;

  mirr_front u_front (
    .instr_word_i (instr_word_i),
    .plan_o       (new_plan)
  );

  mirr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (new_plan),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_plan)
  );

  mirr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (head_valid),
    .plan_i       (head_plan),
    .plan_pop_o   (head_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty         = !res_valid;
  assign action_o      = res.action;
  assign host_reg_o    = res.host_reg;
  assign source_reg_o  = res.source_reg;
  assign slot_offset_o = res.slot_offset;
  assign native_word_o = res.native_word;
  assign last_o        = res.last;

endmodule

[design/mirr_front.sv]
// ----------------------------------------------------------------------------
// mirr_front: instruction classifier
// Checks the multiply form and builds the action plan and rewritten word.
// ----------------------------------------------------------------------------
module mirr_front (
  input  logic [31:0]         instr_word_i,
  output mirr_pkg::plan_t     plan_o
);

  logic [2:0] op;
  logic [4:0] rm, ra, rn, rd, nd;
  logic       group_ok, mulh_ok, accepted;
  logic       rn_res, rm_res, ra_res, rd_res;

  assign op = instr_word_i[23:21];
  assign rm = instr_word_i[20:16];
  assign ra = instr_word_i[14:10];
  assign rn = instr_word_i[9:5];
  assign rd = instr_word_i[4:0];

  assign group_ok = (instr_word_i & mirr_pkg::GroupMask) == mirr_pkg::GroupMatch;
  assign mulh_ok  = (op == mirr_pkg::OpSmulh || op == mirr_pkg::OpUmulh) &&
                    !instr_word_i[15] && (ra == mirr_pkg::RegZero);

  always_comb begin
    accepted = 1'b0;
    if (group_ok) begin
      if (op == mirr_pkg::OpMadd) begin
        accepted = 1'b1;
      end else if (instr_word_i[31]) begin
        accepted = (op == mirr_pkg::OpSmaddl) || (op == mirr_pkg::OpUmaddl) || mulh_ok;
      end
    end
  end

  assign rn_res = mirr_pkg::is_reserved(rn);
  assign rm_res = mirr_pkg::is_reserved(rm);
  assign ra_res = mirr_pkg::is_reserved(ra);
  assign rd_res = (rd != mirr_pkg::RegZero) && mirr_pkg::is_reserved(rd);
  assign nd     = (rd_res || rd == mirr_pkg::RegNine) ? mirr_pkg::RegScrN : rd;

  always_comb begin
    plan_o = '0;
    plan_o.rn = rn;
    plan_o.rm = rm;
    plan_o.ra = ra;
    plan_o.rd = rd;
    plan_o.wb_move = (rd == mirr_pkg::RegNine);
    plan_o.native_word = {instr_word_i[31:21], rm_res ? mirr_pkg::RegScrM : rm,
                          instr_word_i[15], ra_res ? mirr_pkg::RegNine : ra,
                          rn_res ? mirr_pkg::RegScrN : rn, nd};
    if (!accepted) begin
      plan_o.steps[mirr_pkg::StepReject] = 1'b1;
    end else begin
      plan_o.steps[mirr_pkg::StepLoadRn]   = rn_res;
      plan_o.steps[mirr_pkg::StepLoadRm]   = rm_res;
      plan_o.steps[mirr_pkg::StepSave9]    = ra_res;
      plan_o.steps[mirr_pkg::StepLoadRa]   = ra_res;
      plan_o.steps[mirr_pkg::StepEmit]     = 1'b1;
      plan_o.steps[mirr_pkg::StepRestore9] = ra_res;
      plan_o.steps[mirr_pkg::StepWrBack]   = rd_res || (rd == mirr_pkg::RegNine);
    end
  end

endmodule

[design/mirr_queue.sv]
// ----------------------------------------------------------------------------
// mirr_queue: plan queue
// Short register queue between the classifier and the action sequencer.
// ----------------------------------------------------------------------------
module mirr_queue #(
  parameter int unsigned Depth = mirr_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mirr_pkg::plan_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mirr_pkg::plan_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mirr_pkg::plan_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

[design/mirr_back.sv]
// ----------------------------------------------------------------------------
// mirr_back: action sequencer
// Walks the head plan one action per cycle into res_q while free or popped.
// ----------------------------------------------------------------------------
module mirr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plan_valid_i,
  input  mirr_pkg::plan_t   plan_i,
  output logic              plan_pop_o,
  output logic              res_valid_o,
  output mirr_pkg::result_t res_o,
  input  logic              res_pop_i
);

  typedef logic [mirr_pkg::NumSteps-1:0] steps_t;

  steps_t                        done_q, done_d, pending, pick;
  logic                          out_valid_q, out_valid_d, load;
  mirr_pkg::result_t             res_q, res_d;

  assign pending = plan_valid_i ? (plan_i.steps & ~done_q) : '0;
  assign pick    = pending & (~pending + 1'b1);
  assign load    = plan_valid_i && (!out_valid_q || res_pop_i);
  assign plan_pop_o = load && ((pending & ~pick) == '0);

  always_comb begin
    res_d = '0;
    res_d.last = ((pending & ~pick) == '0);
    case (pick)
      (steps_t'(1) << mirr_pkg::StepLoadRn): begin
        res_d.action      = mirr_pkg::ActLoad;
        res_d.host_reg    = mirr_pkg::RegScrN;
        res_d.slot_offset = mirr_pkg::slot_of(plan_i.rn);
      end
      (steps_t'(1) << mirr_pkg::StepLoadRm): begin
        res_d.action      = mirr_pkg::ActLoad;
        res_d.host_reg    = mirr_pkg::RegScrM;
        res_d.slot_offset = mirr_pkg::slot_of(plan_i.rm);
      end
      (steps_t'(1) << mirr_pkg::StepSave9): begin
        res_d.action      = mirr_pkg::ActStore;
        res_d.host_reg    = mirr_pkg::RegNine;
        res_d.slot_offset = mirr_pkg::SlotNine;
      end
      (steps_t'(1) << mirr_pkg::StepLoadRa): begin
        res_d.action      = mirr_pkg::ActLoad;
        res_d.host_reg    = mirr_pkg::RegNine;
        res_d.slot_offset = mirr_pkg::slot_of(plan_i.ra);
      end
      (steps_t'(1) << mirr_pkg::StepEmit): begin
        res_d.action      = mirr_pkg::ActEmit;
        res_d.native_word = plan_i.native_word;
      end
      (steps_t'(1) << mirr_pkg::StepRestore9): begin
        res_d.action      = mirr_pkg::ActLoad;
        res_d.host_reg    = mirr_pkg::RegNine;
        res_d.slot_offset = mirr_pkg::SlotNine;
      end
      (steps_t'(1) << mirr_pkg::StepWrBack): begin
        if (plan_i.wb_move) begin
          res_d.action     = mirr_pkg::ActMove;
          res_d.host_reg   = mirr_pkg::RegNine;
          res_d.source_reg = mirr_pkg::RegScrN;
        end else begin
          res_d.action      = mirr_pkg::ActStore;
          res_d.host_reg    = mirr_pkg::RegScrN;
          res_d.slot_offset = mirr_pkg::slot_of(plan_i.rd);
        end
      end
      default: begin
        res_d.action = mirr_pkg::ActReject;
      end
    endcase
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (res_pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      done_d      = plan_pop_o ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_valid_i |-> ((done_q & ~plan_i.steps) == '0))
    else $error("done steps outside head plan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !plan_valid_i |-> (done_q == '0))
    else $error("stale progress with no plan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plan_valid_i && plan_i.steps[mirr_pkg::StepReject]) |->
      (plan_i.steps == (steps_t'(1) << mirr_pkg::StepReject)))
    else $error("rejected plan carries other steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> $onehot(pick))
    else $error("sequencer loaded without a step");

endmodule
